// File: hw/rtl/rfsp_pkg.sv
// rfsp_pkg: shared types, codes and constants for the replay file stream parser.
// No dependencies.
package rfsp_pkg;

  localparam int unsigned CellSize = 16;

  // record kinds
  localparam logic [2:0] KIND_TEXT  = 3'd0;
  localparam logic [2:0] KIND_DIM   = 3'd1;
  localparam logic [2:0] KIND_MINE  = 3'd2;
  localparam logic [2:0] KIND_PROP  = 3'd3;
  localparam logic [2:0] KIND_MOUSE = 3'd4;
  localparam logic [2:0] KIND_BOARD = 3'd5;
  localparam logic [2:0] KIND_END   = 3'd6;
  localparam logic [2:0] KIND_ERR   = 3'd7;

  // error codes
  localparam logic [2:0] ERR_MAGIC = 3'd0;
  localparam logic [2:0] ERR_TYPE  = 3'd1;
  localparam logic [2:0] ERR_MINE  = 3'd2;
  localparam logic [2:0] ERR_EVENT = 3'd3;
  localparam logic [2:0] ERR_EOF   = 3'd4;

  // one result record
  typedef struct packed {
    logic [2:0]         rec_kind;
    logic [2:0]         item_tag;
    logic [7:0]         char_value;
    logic [4:0]         event_code;
    logic [23:0]        time_ms;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [7:0]         width;
    logic [7:0]         height;
    logic [15:0]        mine_count;
    logic [2:0]         error_code;
  } rec_t;

  // up to two records caused by one byte
  typedef struct packed {
    logic  two;
    rec_t  r0;
    rec_t  r1;
  } entry_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

endpackage

// File: hw/rtl/rfsp_front.sv
// rfsp_front: byte-level phase machine; classifies each byte into 0..2 records.
// Depends on rfsp_pkg.
module rfsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic [7:0]            byte_value,
  input  logic                  stream_end,
  output logic                  ent_valid,
  output rfsp_pkg::entry_t      ent
);

  localparam logic [4:0] PH_HEAD = 5'd0, PH_SKIPA = 5'd1, PH_BBBV = 5'd2, PH_SKIPB = 5'd3,
    PH_STAMP = 5'd4, PH_GAP2 = 5'd5, PH_PROG = 5'd6, PH_GAP3 = 5'd7, PH_VER = 5'd8,
    PH_GAP1 = 5'd9, PH_NPI = 5'd10, PH_PLEN = 5'd11, PH_PCHR = 5'd12, PH_GAP4 = 5'd13,
    PH_W = 5'd14, PH_H = 5'd15, PH_M = 5'd16, PH_MINE = 5'd17, PH_NPF = 5'd18,
    PH_FLAG = 5'd19, PH_PROP = 5'd20, PH_PSKIP = 5'd21, PH_EV = 5'd22, PH_EVT = 5'd23,
    PH_MOUSE = 5'd24, PH_BOARD = 5'd25, PH_DONE = 5'd26, PH_ERR = 5'd27;

  logic [4:0]  phase, phase_next;
  logic [4:0]  bidx, bidx_next;        // header needs 0..28
  logic [15:0] shift, shift_next;
  logic [15:0] rlen, rlen_next, vlen, vlen_next, flen, flen_next, plen, plen_next;
  logic [15:0] npf, npf_next;
  logic [7:0]  srem, srem_next, cols, cols_next, rows, rows_next;
  logic [15:0] cnt, cnt_next;
  logic        first, first_next;
  logic [4:0]  pev, pev_next;
  logic [23:0] ptime, ptime_next;
  logic [16:0] pco, pco_next;
  logic        ov, ov_next;
  rfsp_pkg::entry_t oent, oent_next;

  // entry into a phase: resolves empty counts by chaining forward
  function automatic logic [20:0] enter_ph(input logic [4:0] p, input logic [15:0] c,
      input logic [15:0] rl, input logic [15:0] vl, input logic [15:0] fl,
      input logic [15:0] pl);
    logic [4:0] q;
    logic [15:0] n;
    logic [15:0] cc;
    logic done;
    q = p; cc = c; n = 16'd0; done = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (!done) begin
        unique case (q)
          PH_SKIPA: begin
            n = (rl > 16'd35) ? rl - 16'd32 : (rl > 16'd3) ? rl - 16'd3 : 16'd0;
            if (n == 0) q = PH_GAP2; else done = 1'b1;
          end
          PH_BBBV:  begin n = 16'd3; done = 1'b1; end
          PH_SKIPB: begin n = 16'd16; done = 1'b1; end
          PH_STAMP: begin n = 16'd10; done = 1'b1; end
          PH_GAP2:  begin n = 16'd2; done = 1'b1; end
          PH_PROG:  begin n = 16'd18; done = 1'b1; end
          PH_GAP3:  begin n = 16'd3; done = 1'b1; end
          PH_VER: begin
            n = (vl > 16'd22) ? vl - 16'd22 : 16'd0;
            if (n == 0) q = PH_GAP1; else done = 1'b1;
          end
          PH_GAP1:  begin n = 16'd1; done = 1'b1; end
          PH_NPI:   begin n = 16'd2; done = 1'b1; end
          PH_GAP4:  begin n = 16'd4; done = 1'b1; end
          PH_M:     begin n = 16'd2; done = 1'b1; end
          PH_MINE: begin
            n = cc;
            if (n == 0) begin q = (fl != 0) ? PH_NPF : PH_PROP; cc = 16'd0; end
            else done = 1'b1;
          end
          PH_NPF:   begin n = 16'd2; done = 1'b1; end
          PH_FLAG: begin
            n = cc;
            if (n == 0) begin q = PH_PROP; cc = 16'd0; end else done = 1'b1;
          end
          PH_PROP:  begin n = 16'd4; done = 1'b1; end
          PH_PSKIP: begin
            n = (pl > 16'd4) ? pl - 16'd4 : 16'd0;
            if (n == 0) q = PH_EV; else done = 1'b1;
          end
          PH_EVT:   begin n = 16'd4; done = 1'b1; end
          default:  begin n = 16'd1; done = 1'b1; end
        endcase
      end
    end
    return {q, n};
  endfunction

  always_comb begin
    logic [15:0] v16;
    logic [20:0] en;
    logic        go;
    logic [4:0]  tgt;
    logic [15:0] tcnt;
    logic        er;
    logic [2:0]  ecode;
    logic [15:0] cdec;
    logic [16:0] yv;
    logic [16:0] fx, fy;
    rfsp_pkg::rec_t r;
    phase_next = phase; bidx_next = bidx; shift_next = shift;
    rlen_next = rlen; vlen_next = vlen; flen_next = flen; plen_next = plen;
    npf_next = npf; srem_next = srem; cols_next = cols; rows_next = rows;
    cnt_next = cnt; first_next = first; pev_next = pev; ptime_next = ptime;
    pco_next = pco;
    ov_next = 1'b0; oent_next = '0;
    go = 1'b0; tgt = phase; tcnt = 16'd0; er = 1'b0; ecode = rflt_err();
    r = '0;
    v16 = {shift[7:0], byte_value};
    cdec = cnt - 16'd1;
    yv = '0; fx = '0; fy = '0;
    en = '0;
    if (in_fire) begin
      if (stream_end) begin
        if (phase != PH_DONE && phase != PH_ERR) begin
          ov_next = 1'b1;
          oent_next.r0.rec_kind = rfsp_pkg::KIND_ERR;
          oent_next.r0.error_code = rfsp_pkg::ERR_EOF;
        end
        phase_next = PH_HEAD; bidx_next = '0; shift_next = '0; rlen_next = '0;
        vlen_next = '0; flen_next = '0; plen_next = '0; npf_next = '0; srem_next = '0;
        cols_next = '0; rows_next = '0; cnt_next = '0; first_next = 1'b1;
        pev_next = '0; ptime_next = '0; pco_next = '0;
      end else begin
        unique case (phase)
          PH_HEAD: begin
            if (bidx < 5'd4) begin
              if (byte_value != magic(bidx[1:0])) begin er = 1'b1; ecode = rfsp_pkg::ERR_MAGIC; end
              else bidx_next = bidx + 5'd1;
            end else if (bidx < 5'd28) begin
              shift_next = v16;
              if (bidx == 5'd5 && v16 != 16'd1) begin er = 1'b1; ecode = rfsp_pkg::ERR_TYPE; end
              else begin
                if (bidx == 5'd11) rlen_next = v16;
                if (bidx == 5'd13) vlen_next = v16;
                if (bidx == 5'd19) flen_next = v16;
                if (bidx == 5'd21) plen_next = v16;
                bidx_next = bidx + 5'd1;
              end
            end else begin go = 1'b1; tgt = PH_SKIPA; end
          end
          PH_SKIPA: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1;
            tgt = (rlen > 16'd35) ? PH_BBBV : PH_GAP2; end end
          PH_BBBV: begin
            r.rec_kind = rfsp_pkg::KIND_TEXT; r.item_tag = 3'd0;
            r.char_value = (byte_value >= 8'd48 && byte_value <= 8'd57) ? byte_value : 8'd32;
            ov_next = 1'b1; oent_next.r0 = r;
            cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_SKIPB; end
          end
          PH_SKIPB: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_STAMP; end end
          PH_STAMP, PH_PROG, PH_VER: begin
            r.rec_kind = rfsp_pkg::KIND_TEXT;
            r.item_tag = (phase == PH_STAMP) ? 3'd1 : (phase == PH_PROG) ? 3'd2 : 3'd3;
            r.char_value = byte_value; ov_next = 1'b1; oent_next.r0 = r;
            cnt_next = cdec;
            if (cdec == 0) begin go = 1'b1;
              tgt = (phase == PH_STAMP) ? PH_GAP2 : (phase == PH_PROG) ? PH_GAP3 : PH_GAP1; end
          end
          PH_GAP2: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_PROG; end end
          PH_GAP3: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_VER; end end
          PH_GAP1: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_NPI; end end
          PH_NPI: begin
            shift_next = v16; cnt_next = cdec;
            if (cdec == 0) begin
              npf_next = v16; bidx_next = '0;
              if (v16 != 0) begin phase_next = PH_PLEN; cnt_next = 16'd1; end
              else begin go = 1'b1; tgt = PH_GAP4; end
            end
          end
          PH_PLEN: begin
            srem_next = byte_value;
            if (byte_value == 0) begin
              bidx_next = bidx + 5'd1;
              if (bidx + 5'd1 < 5'd4 && {11'd0, bidx + 5'd1} < npf) begin
                phase_next = PH_PLEN; cnt_next = 16'd1;
              end else begin go = 1'b1; tgt = PH_GAP4; end
            end else phase_next = PH_PCHR;
          end
          PH_PCHR: begin
            r.rec_kind = rfsp_pkg::KIND_TEXT; r.item_tag = 3'd4 + {1'b0, bidx[1:0]};
            r.char_value = byte_value; ov_next = 1'b1; oent_next.r0 = r;
            srem_next = srem - 8'd1;
            if (srem == 8'd1) begin
              bidx_next = bidx + 5'd1;
              if (bidx + 5'd1 < 5'd4 && {11'd0, bidx + 5'd1} < npf) begin
                phase_next = PH_PLEN; cnt_next = 16'd1;
              end else begin go = 1'b1; tgt = PH_GAP4; end
            end
          end
          PH_GAP4: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_W; end end
          PH_W: begin cols_next = byte_value; go = 1'b1; tgt = PH_H; end
          PH_H: begin rows_next = byte_value; go = 1'b1; tgt = PH_M; end
          PH_M: begin
            shift_next = v16; cnt_next = cdec;
            if (cdec == 0) begin
              r.rec_kind = rfsp_pkg::KIND_DIM; r.width = cols; r.height = rows;
              r.mine_count = v16; ov_next = 1'b1; oent_next.r0 = r;
              go = 1'b1; tgt = PH_MINE; tcnt = v16;
            end
          end
          PH_MINE: begin
            if (bidx == 0) begin pco_next = {9'd0, byte_value}; bidx_next = 5'd1; end
            else begin
              bidx_next = '0;
              if (pco[7:0] >= cols || pco[16:8] != 0 || byte_value >= rows) begin
                er = 1'b1; ecode = rfsp_pkg::ERR_MINE;
              end else begin
                r.rec_kind = rfsp_pkg::KIND_MINE; r.pos_x = pco; r.pos_y = {9'd0, byte_value};
                ov_next = 1'b1; oent_next.r0 = r;
                cnt_next = cdec;
                if (cdec == 0) begin go = 1'b1; tgt = (flen != 0) ? PH_NPF : PH_PROP; end
              end
            end
          end
          PH_NPF: begin
            shift_next = v16; cnt_next = cdec;
            if (cdec == 0) begin go = 1'b1; tgt = PH_FLAG; tcnt = v16; end
          end
          PH_FLAG: begin
            if (bidx == 0) begin pco_next = {9'd0, byte_value}; bidx_next = 5'd1; end
            else begin
              bidx_next = '0;
              fx = 17'(rfsp_pkg::CellSize / 2) + 17'(pco[7:0]) * 17'(rfsp_pkg::CellSize);
              fy = 17'(rfsp_pkg::CellSize / 2) + 17'(byte_value) * 17'(rfsp_pkg::CellSize);
              r.rec_kind = rfsp_pkg::KIND_MOUSE; r.pos_x = fx; r.pos_y = fy;
              r.event_code = 5'd4; oent_next.r0 = r;
              r.event_code = 5'd5; oent_next.r1 = r; oent_next.two = 1'b1;
              ov_next = 1'b1;
              cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_PROP; end
            end
          end
          PH_PROP: begin
            r.rec_kind = rfsp_pkg::KIND_PROP; r.item_tag = 3'(3'd4 - cnt[2:0]);
            r.char_value = byte_value; ov_next = 1'b1; oent_next.r0 = r;
            cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_PSKIP; end
          end
          PH_PSKIP: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_EV; end end
          PH_EV: begin
            if (byte_value == 0) begin go = 1'b1; tgt = PH_EVT; end
            else if (byte_value <= 8'd7) begin
              pev_next = byte_value[4:0]; go = 1'b1; tgt = PH_MOUSE; ptime_next = '0;
            end else if (byte_value == 8'd8) begin er = 1'b1; ecode = rfsp_pkg::ERR_EVENT; end
            else if (byte_value <= 8'd14 || (byte_value >= 8'd18 && byte_value <= 8'd27)) begin
              pev_next = byte_value[4:0]; go = 1'b1; tgt = PH_BOARD;
            end else if (byte_value <= 8'd17) begin
              r.rec_kind = rfsp_pkg::KIND_END; r.event_code = byte_value[4:0];
              ov_next = 1'b1; oent_next.r0 = r; go = 1'b1; tgt = PH_DONE;
            end else begin er = 1'b1; ecode = rfsp_pkg::ERR_EVENT; end
          end
          PH_EVT: begin cnt_next = cdec; if (cdec == 0) begin go = 1'b1; tgt = PH_EV; end end
          PH_MOUSE: begin
            bidx_next = bidx + 5'd1;
            if (bidx < 5'd3) ptime_next = {ptime[15:0], byte_value};
            else if (bidx == 5'd4 || bidx == 5'd6) shift_next = {8'd0, byte_value};
            else if (bidx == 5'd5) pco_next = {1'b0, shift[7:0], byte_value} - 17'd12;
            else if (bidx == 5'd7) begin
              yv = {1'b0, shift[7:0], byte_value} - 17'd56;
              r.rec_kind = rfsp_pkg::KIND_MOUSE; r.time_ms = ptime; r.pos_x = pco;
              r.pos_y = yv; r.event_code = pev;
              if (first) begin
                first_next = 1'b0; oent_next.r1 = r; oent_next.two = 1'b1;
                r.event_code = 5'd2; oent_next.r0 = r;
              end else oent_next.r0 = r;
              ov_next = 1'b1; go = 1'b1; tgt = PH_EV;
            end
          end
          PH_BOARD: begin
            if (bidx == 0) begin pco_next = {9'd0, byte_value} + 17'd1; bidx_next = 5'd1; end
            else begin
              r.rec_kind = rfsp_pkg::KIND_BOARD; r.event_code = pev; r.pos_x = pco;
              r.pos_y = {9'd0, byte_value} + 17'd1;
              ov_next = 1'b1; oent_next.r0 = r; go = 1'b1; tgt = PH_EV;
            end
          end
          default: ;
        endcase
        if (er) begin
          ov_next = 1'b1; oent_next = '0;
          oent_next.r0.rec_kind = rfsp_pkg::KIND_ERR; oent_next.r0.error_code = ecode;
          go = 1'b1; tgt = PH_ERR;
        end
        if (go) begin
          en = enter_ph(tgt, tcnt, rlen, vlen, flen, plen);
          phase_next = en[20:16]; cnt_next = en[15:0]; bidx_next = '0; shift_next = '0;
        end
      end
    end
  end

  function automatic logic [2:0] rflt_err();
    return rfsp_pkg::ERR_MAGIC;
  endfunction

  function automatic logic [7:0] magic(input logic [1:0] i);
    unique case (i)
      2'd0: return 8'd42;
      2'd1: return 8'd114;
      2'd2: return 8'd109;
      default: return 8'd118;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD; bidx <= '0; shift <= '0; rlen <= '0; vlen <= '0; flen <= '0;
      plen <= '0; npf <= '0; srem <= '0; cols <= '0; rows <= '0; cnt <= '0;
      first <= 1'b1; pev <= '0; ptime <= '0; pco <= '0; ov <= 1'b0;
    end else begin
      phase <= phase_next; bidx <= bidx_next; shift <= shift_next; rlen <= rlen_next;
      vlen <= vlen_next; flen <= flen_next; plen <= plen_next; npf <= npf_next;
      srem <= srem_next; cols <= cols_next; rows <= rows_next; cnt <= cnt_next;
      first <= first_next; pev <= pev_next; ptime <= ptime_next; pco <= pco_next;
      ov <= ov_next;
    end
  end

  always_ff @(posedge clk) oent <= oent_next;

  assign ent_valid = ov;
  assign ent = oent;

`ifndef ASSERT_OFF
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(in_fire) |-> !ent_valid) else $error("front record without byte");
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !stream_end && (phase == PH_DONE || phase == PH_ERR)) |=> !ent_valid)
    else $error("record after end");
  a_two_mouse: assert property (@(posedge clk) disable iff (rst)
    (ent_valid && ent.two) |-> ent.r1.rec_kind == rfsp_pkg::KIND_MOUSE)
    else $error("pair not mouse");
`endif

endmodule

// File: hw/rtl/rfsp_back.sv
// rfsp_back: entry queue and output stage; splits paired entries into two words.
// Depends on rfsp_pkg.
module rfsp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             ent_valid,
  input  rfsp_pkg::entry_t ent,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output rfsp_pkg::rec_t   out_rec,
  output logic             out_last
);

  rfsp_pkg::entry_t q [rfsp_pkg::QDepth];
  logic [rfsp_pkg::QAw-1:0] wp, rp;
  logic [rfsp_pkg::QAw:0]   cnt;
  logic half;                        // second record of head entry in flight
  logic pop;

  assign out_valid = (cnt != 0);
  assign out_rec   = half ? q[rp].r1 : q[rp].r0;
  assign out_last  = half || !q[rp].two;
  assign pop       = out_valid && out_ready && out_last;
  // one entry may sit in the front register unseen; keep room for it
  assign space_ok  = (cnt + {{rfsp_pkg::QAw{1'b0}}, ent_valid})
                     < (rfsp_pkg::QAw + 1)'(rfsp_pkg::QDepth);

  always_ff @(posedge clk) begin
    if (ent_valid) q[wp] <= ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; half <= 1'b0;
    end else begin
      if (ent_valid) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (ent_valid ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      if (out_valid && out_ready) half <= !out_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (rfsp_pkg::QAw + 1)'(rfsp_pkg::QDepth)) else $error("queue overflow");
  a_half_two: assert property (@(posedge clk) disable iff (rst)
    half |-> (out_valid && q[rp].two)) else $error("half without pair");
  a_half_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == 0) |-> !half) else $error("half on empty queue");
`endif

endmodule

// File: hw/rtl/replay_file_stream_parser.sv
// replay_file_stream_parser: top level, front classifier plus back queue.
// Depends on rfsp_pkg, rfsp_front, rfsp_back.
//
//  channel | dir | fields
//  s_axis  | in  | tdata[7:0]=byte_value, tuser=stream_end
//  m_axis  | out | tuser=rec_kind, tdata=record fields (see below), tlast=last_of_run
//
// One byte accepted per cycle while the queue has room; the front phase machine
// registers 0..2 records per byte in the next cycle. A four-entry queue
// decouples it from the output. A paired byte (flag press/release, first
// mouse click) yields two output words. rst is synchronous and returns the parser
// to the header phase. Input stalls only when the queue has no room.
module replay_file_stream_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // byte_value
  input  logic         s_axis_tuser,   // stream_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // item_tag[2:0], char_value[10:3], event_code[15:11], time_ms[39:16],
  // pos_x[56:40], pos_y[73:57], width[81:74], height[89:82],
  // mine_count[105:90], error_code[108:106], zero fill[111:109]
  output logic [111:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // rec_kind
  output logic         m_axis_tlast    // last_of_run
);

  logic             ent_valid, space_ok, fire;
  rfsp_pkg::entry_t ent;
  rfsp_pkg::rec_t   rec;

  assign s_axis_tready = space_ok;
  assign fire = s_axis_tvalid && s_axis_tready;

  rfsp_front u_front (
    .clk, .rst, .in_fire(fire), .byte_value(s_axis_tdata), .stream_end(s_axis_tuser),
    .ent_valid, .ent
  );

  rfsp_back u_back (
    .clk, .rst, .ent_valid, .ent, .space_ok,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rec(rec),
    .out_last(m_axis_tlast)
  );

  assign m_axis_tuser = rec.rec_kind;
  assign m_axis_tdata = {3'd0, rec.error_code, rec.mine_count, rec.height, rec.width,
                         rec.pos_y, rec.pos_x, rec.time_ms, rec.event_code,
                         rec.char_value, rec.item_tag};

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("valid dropped");
  a_stall_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("word changed while stalled");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != rfsp_pkg::KIND_ERR) |-> m_axis_tdata[108:106] == 3'd0)
    else $error("error code on non-error word");
`endif

endmodule

// File: tb/record_checker.sv
// record_checker: tracks the byte stream into the replay parser, predicts the
// records it must emit and compares them with the output words. Uses rfsp_pkg.
`timescale 1ns / 1ps
module record_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           errors,
  output int           pending
);

  typedef enum logic [5:0] {
    P_HEAD, P_SKIPA, P_BBBV, P_SKIPB, P_STAMP, P_GAP2, P_PROG, P_GAP3, P_VER,
    P_GAP1, P_NPI, P_PLEN, P_PCHR, P_GAP4, P_W, P_H, P_M, P_MINE, P_NPF,
    P_FLAG, P_PROP, P_PSKIP, P_EV, P_EVT, P_MOUSE, P_BOARD, P_DONE, P_ERR
  } phase_t;

  typedef struct {
    rfsp_pkg::rec_t r;
    bit             last;
  } record_t;

  localparam logic [2:0] TAG_BBBV  = 3'd0;
  localparam logic [2:0] TAG_STAMP = 3'd1;
  localparam logic [2:0] TAG_PROG  = 3'd2;
  localparam logic [2:0] TAG_VER   = 3'd3;
  localparam logic [2:0] TAG_NAME  = 3'd4;
  localparam int unsigned EV_LCLICK = 2;
  localparam int unsigned EV_RPRESS = 4;
  localparam int unsigned EV_RREL   = 5;
  localparam byte unsigned MAGIC [4] = '{8'd42, 8'd114, 8'd109, 8'd118};

  record_t        record_q[$];
  rfsp_pkg::rec_t step_recs[2];
  int             step_n;

  // parser image
  phase_t      ph;
  int unsigned idx, shf, res_len, ver_len, flag_len, prop_len, fields;
  int unsigned str_left, cols, rows, left, first_click, ev_code, ev_time, coord;

  function automatic void clear_parser();
    ph = P_HEAD; idx = 0; shf = 0; res_len = 0; ver_len = 0; flag_len = 0;
    prop_len = 0; fields = 0; str_left = 0; cols = 0; rows = 0; left = 0;
    first_click = 1; ev_code = 0; ev_time = 0; coord = 0;
  endfunction

  function automatic void add_rec(logic [2:0] kind, int unsigned tag, int unsigned ch,
                                  int unsigned ev, int unsigned t, int unsigned x,
                                  int unsigned y, int unsigned w = 0, int unsigned h = 0,
                                  int unsigned mc = 0, logic [2:0] ec = 3'd0);
    rfsp_pkg::rec_t r;
    if (step_n >= 2) return;
    r = '0;
    r.rec_kind = kind; r.item_tag = tag[2:0]; r.char_value = ch[7:0];
    r.event_code = ev[4:0]; r.time_ms = t[23:0];
    r.pos_x = x[16:0]; r.pos_y = y[16:0];
    r.width = w[7:0]; r.height = h[7:0]; r.mine_count = mc[15:0]; r.error_code = ec;
    step_recs[step_n] = r;
    step_n++;
  endfunction

  // enter a phase; phases with nothing to read fall through to the next one
  function automatic void go(phase_t p, int unsigned cnt);
    int unsigned n;
    phase_t nxt;
    while (1) begin
      n = 0; nxt = p;
      ph = p; idx = 0; shf = 0;
      case (p)
        P_SKIPA: begin
          if (res_len > 35) n = res_len - 32;
          else if (res_len > 3) n = res_len - 3;
          nxt = res_len > 35 ? P_BBBV : P_GAP2;
        end
        P_BBBV:  n = 3;
        P_SKIPB: n = 16;
        P_STAMP: n = 10;
        P_GAP2:  n = 2;
        P_PROG:  n = 18;
        P_GAP3:  n = 3;
        P_VER: begin
          n = ver_len > 22 ? ver_len - 22 : 0;
          nxt = P_GAP1;
        end
        P_GAP1:  n = 1;
        P_NPI:   n = 2;
        P_GAP4:  n = 4;
        P_M:     n = 2;
        P_MINE: begin
          n = cnt;
          nxt = flag_len != 0 ? P_NPF : P_PROP;
        end
        P_NPF:   n = 2;
        P_FLAG: begin n = cnt; nxt = P_PROP; end
        P_PROP:  n = 4;
        P_PSKIP: begin
          n = prop_len > 4 ? prop_len - 4 : 0;
          nxt = P_EV;
        end
        P_EVT:   n = 4;
        P_MOUSE: begin ev_time = 0; n = 1; end
        default: n = 1;
      endcase
      left = n & 16'hFFFF;
      if (left != 0) return;
      p = nxt;
      cnt = 0;
    end
  endfunction

  function automatic void fail_with(logic [2:0] ec);
    add_rec(rfsp_pkg::KIND_ERR, 0, 0, 0, 0, 0, 0, 0, 0, 0, ec);
    go(P_ERR, 0);
  endfunction

  function automatic void next_field();
    if (idx < 4 && idx < fields) begin
      ph = P_PLEN;
      left = 1;
    end else begin
      go(P_GAP4, 0);
    end
  endfunction

  function automatic void tick(phase_t nxt);
    left = (left - 1) & 16'hFFFF;
    if (left == 0) go(nxt, 0);
  endfunction

  function automatic int unsigned take16(int unsigned b);
    shf = ((shf << 8) | b) & 16'hFFFF;
    return shf;
  endfunction

  function automatic void parse_byte(int unsigned b);
    int unsigned v, x, y;
    case (ph)
      P_HEAD: begin
        if (idx < 4) begin
          if (b != MAGIC[idx]) begin fail_with(rfsp_pkg::ERR_MAGIC); return; end
        end else if (idx < 28) begin
          v = take16(b);
          if (idx == 5 && v != 1) begin fail_with(rfsp_pkg::ERR_TYPE); return; end
          if (idx == 11) res_len = v;
          if (idx == 13) ver_len = v;
          if (idx == 19) flag_len = v;
          if (idx == 21) prop_len = v;
        end else begin
          go(P_SKIPA, 0);
          return;
        end
        idx++;
      end
      P_SKIPA: tick(res_len > 35 ? P_BBBV : P_GAP2);
      P_BBBV: begin
        add_rec(rfsp_pkg::KIND_TEXT, TAG_BBBV, (b >= 48 && b <= 57) ? b : 32, 0, 0, 0, 0);
        tick(P_SKIPB);
      end
      P_SKIPB: tick(P_STAMP);
      P_STAMP: begin add_rec(rfsp_pkg::KIND_TEXT, TAG_STAMP, b, 0, 0, 0, 0); tick(P_GAP2); end
      P_GAP2:  tick(P_PROG);
      P_PROG:  begin add_rec(rfsp_pkg::KIND_TEXT, TAG_PROG, b, 0, 0, 0, 0); tick(P_GAP3); end
      P_GAP3:  tick(P_VER);
      P_VER:   begin add_rec(rfsp_pkg::KIND_TEXT, TAG_VER, b, 0, 0, 0, 0); tick(P_GAP1); end
      P_GAP1:  tick(P_NPI);
      P_NPI: begin
        v = take16(b);
        left = (left - 1) & 16'hFFFF;
        if (left == 0) begin
          fields = v;
          idx = 0;
          next_field();
        end
      end
      P_PLEN: begin
        str_left = b;
        if (b == 0) begin idx++; next_field(); end
        else ph = P_PCHR;
      end
      P_PCHR: begin
        add_rec(rfsp_pkg::KIND_TEXT, TAG_NAME + (idx & 3), b, 0, 0, 0, 0);
        str_left = (str_left - 1) & 8'hFF;
        if (str_left == 0) begin idx++; next_field(); end
      end
      P_GAP4: tick(P_W);
      P_W: begin cols = b; go(P_H, 0); end
      P_H: begin rows = b; go(P_M, 0); end
      P_M: begin
        v = take16(b);
        left = (left - 1) & 16'hFFFF;
        if (left == 0) begin
          add_rec(rfsp_pkg::KIND_DIM, 0, 0, 0, 0, 0, 0, cols, rows, v);
          go(P_MINE, v);
        end
      end
      P_MINE: begin
        if (idx == 0) begin
          coord = b; idx = 1;
        end else begin
          idx = 0;
          if (coord >= cols || b >= rows) fail_with(rfsp_pkg::ERR_MINE);
          else begin
            add_rec(rfsp_pkg::KIND_MINE, 0, 0, 0, 0, coord, b);
            tick(flag_len != 0 ? P_NPF : P_PROP);
          end
        end
      end
      P_NPF: begin
        v = take16(b);
        left = (left - 1) & 16'hFFFF;
        if (left == 0) go(P_FLAG, v);
      end
      P_FLAG: begin
        if (idx == 0) begin
          coord = b; idx = 1;
        end else begin
          idx = 0;
          x = rfsp_pkg::CellSize / 2 + coord * rfsp_pkg::CellSize;
          y = rfsp_pkg::CellSize / 2 + b * rfsp_pkg::CellSize;
          add_rec(rfsp_pkg::KIND_MOUSE, 0, 0, EV_RPRESS, 0, x, y);
          add_rec(rfsp_pkg::KIND_MOUSE, 0, 0, EV_RREL, 0, x, y);
          tick(P_PROP);
        end
      end
      P_PROP: begin
        add_rec(rfsp_pkg::KIND_PROP, (4 - left) & 3, b, 0, 0, 0, 0);
        tick(P_PSKIP);
      end
      P_PSKIP: tick(P_EV);
      P_EV: begin
        if (b == 0) go(P_EVT, 0);
        else if (b <= 7) begin ev_code = b; go(P_MOUSE, 0); end
        else if (b == 8) fail_with(rfsp_pkg::ERR_EVENT);
        else if (b <= 14 || (b >= 18 && b <= 27)) begin ev_code = b; go(P_BOARD, 0); end
        else if (b <= 17) begin
          add_rec(rfsp_pkg::KIND_END, 0, 0, b, 0, 0, 0);
          go(P_DONE, 0);
        end
        else fail_with(rfsp_pkg::ERR_EVENT);
      end
      P_EVT: tick(P_EV);
      P_MOUSE: begin
        if (idx < 3) ev_time = ((ev_time << 8) | b) & 24'hFFFFFF;
        else if (idx == 4 || idx == 6) shf = b;
        else if (idx == 5) coord = (((shf << 8) | b) - 12) & 17'h1FFFF;
        else if (idx == 7) begin
          y = ((shf << 8) | b) - 56;
          if (first_click != 0) begin
            first_click = 0;
            add_rec(rfsp_pkg::KIND_MOUSE, 0, 0, EV_LCLICK, ev_time, coord, y);
          end
          add_rec(rfsp_pkg::KIND_MOUSE, 0, 0, ev_code, ev_time, coord, y);
          go(P_EV, 0);
          return;
        end
        idx++;
      end
      P_BOARD: begin
        if (idx == 0) begin
          coord = b + 1; idx = 1;
        end else begin
          add_rec(rfsp_pkg::KIND_BOARD, 0, 0, ev_code, 0, coord, b + 1);
          go(P_EV, 0);
        end
      end
      default: ;
    endcase
  endfunction

  // one accepted input word -> 0..2 expected records
  function automatic void predict_records(logic [7:0] b, logic eof);
    step_n = 0;
    if (eof) begin
      if (ph != P_DONE && ph != P_ERR) fail_with(rfsp_pkg::ERR_EOF);
      clear_parser();
    end else begin
      parse_byte(b);
    end
    for (int i = 0; i < step_n; i++)
      record_q.push_back('{r: step_recs[i], last: (i == step_n - 1)});
  endfunction

  task automatic report(string what, logic [111:0] got, logic [111:0] want);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic logic [111:0] pack_rec(rfsp_pkg::rec_t r);
    return {3'd0, r.error_code, r.mine_count, r.height, r.width, r.pos_y, r.pos_x,
            r.time_ms, r.event_code, r.char_value, r.item_tag};
  endfunction

  task automatic compare_word();
    record_t w;
    logic [111:0] d, e;
    d = m_axis_tdata;
    if (record_q.size() == 0) begin
      report("unexpected word", d, '0);
      return;
    end
    w = record_q.pop_front();
    e = pack_rec(w.r);
    if (m_axis_tuser !== w.r.rec_kind)
      report("rec_kind", {109'd0, m_axis_tuser}, {109'd0, w.r.rec_kind});
    if (d[2:0]     !== e[2:0])     report("item_tag", d, e);
    if (d[10:3]    !== e[10:3])    report("char_value", d, e);
    if (d[15:11]   !== e[15:11])   report("event_code", d, e);
    if (d[39:16]   !== e[39:16])   report("time_ms", d, e);
    if (d[56:40]   !== e[56:40])   report("pos_x", d, e);
    if (d[73:57]   !== e[73:57])   report("pos_y", d, e);
    if (d[81:74]   !== e[81:74])   report("width", d, e);
    if (d[89:82]   !== e[89:82])   report("height", d, e);
    if (d[105:90]  !== e[105:90])  report("mine_count", d, e);
    if (d[108:106] !== e[108:106]) report("error_code", d, e);
    if (d[111:109] !== e[111:109]) report("zero fill", d, e);
    if (m_axis_tlast !== w.last)   report("tlast", {111'd0, m_axis_tlast}, {111'd0, w.last});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      errors = 0;
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_records(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) compare_word();
      pending <= record_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// testbench: builds replay files (mostly well formed, some truncated or corrupted),
// streams them into replay_file_stream_parser and gives the verdict.
// Depends on rfsp_pkg, replay_file_stream_parser and record_checker.
`timescale 1ns / 1ps
module testbench;

  localparam int TARGET_WORDS = 1550;
  localparam int CYCLE_LIMIT  = 300000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int errors, pending;
  int cycles = 0;
  int sent = 0;
  bit in_burst = 0;   // sender idles on no word while set
  bit out_burst = 0;  // receiver draws no new stall while set
  int stall_left = 0;
  int out_gap;
  byte unsigned file_q[$];

  replay_file_stream_parser i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  record_checker i_chk (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: draws a random stall after each accepted word unless out_burst is set
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid && !out_burst) begin
      out_gap = int'($urandom_range(0, 3));
      stall_left <= (out_gap > 0) ? out_gap - 1 : 0;
      m_axis_tready <= (out_gap == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one word into the parser; valid stays high across back-to-back words
  task automatic send_word(input logic [7:0] b, input logic eof);
    int gap;
    gap = in_burst ? 0 : int'($urandom_range(0, 3));
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put16(int unsigned v);
    file_q.push_back(v[15:8]);
    file_q.push_back(v[7:0]);
  endtask

  task automatic put_rand(int n);
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // assembles one file with random content; sizes follow the header fields
  task automatic build_file();
    int unsigned rl, vl, fl, pl, nf, len, w, h, nm, nflag, nev, code, pick;
    file_q.delete();
    rl = ($urandom_range(0, 1) != 0) ? $urandom_range(36, 50) : $urandom_range(0, 35);
    vl = $urandom_range(0, 30);
    fl = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 300) : 0;
    pl = $urandom_range(0, 9);
    file_q = '{8'd42, 8'd114, 8'd109, 8'd118};
    put_rand(24);
    file_q[4] = 8'd0; file_q[5] = 8'd1;
    file_q[10] = rl[15:8]; file_q[11] = rl[7:0];
    file_q[12] = vl[15:8]; file_q[13] = vl[7:0];
    file_q[18] = fl[15:8]; file_q[19] = fl[7:0];
    file_q[20] = pl[15:8]; file_q[21] = pl[7:0];
    put_rand(1);
    // result text, program, version, gaps
    if (rl > 35) put_rand(rl - 32 + 3 + 16 + 10);
    else if (rl > 3) put_rand(rl - 3);
    put_rand(2 + 18 + 3 + (vl > 22 ? vl - 22 : 0) + 1);
    // player fields
    nf = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 65535) : $urandom_range(0, 5);
    put16(nf);
    for (int i = 0; i < 4 && i < nf; i++) begin
      len = $urandom_range(0, 6);
      file_q.push_back(len[7:0]);
      put_rand(len);
    end
    put_rand(4);
    // board
    pick = $urandom_range(0, 9);
    w = pick == 0 ? 0 : pick == 1 ? 255 : $urandom_range(1, 30);
    h = pick == 2 ? 0 : pick == 3 ? 255 : $urandom_range(1, 24);
    nm = $urandom_range(0, 5);
    file_q.push_back(w[7:0]);
    file_q.push_back(h[7:0]);
    put16(nm);
    for (int i = 0; i < nm; i++) begin
      if ($urandom_range(0, 14) == 0 || w == 0 || h == 0) begin
        put_rand(2);
      end else begin
        file_q.push_back(8'($urandom_range(0, w - 1)));
        file_q.push_back(8'($urandom_range(0, h - 1)));
      end
    end
    if (fl != 0) begin
      nflag = $urandom_range(0, 3);
      put16(nflag);
      put_rand(2 * nflag);
    end
    put_rand(4 + (pl > 4 ? pl - 4 : 0));
    // event log
    nev = $urandom_range(0, 12);
    for (int i = 0; i < nev; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        file_q.push_back(8'($urandom_range(1, 7)));
        put_rand(8);
      end else if (pick < 8) begin
        code = $urandom_range(0, 1) != 0 ? $urandom_range(9, 14) : $urandom_range(18, 27);
        file_q.push_back(code[7:0]);
        put_rand(2);
      end else begin
        file_q.push_back(8'd0);
        put_rand(4);
      end
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) file_q.push_back(8'd8);
    else if (pick == 1) file_q.push_back(8'($urandom_range(28, 255)));
    else file_q.push_back(8'($urandom_range(15, 17)));
    put_rand($urandom_range(0, 3));  // trailing bytes after the end record
  endtask

  task automatic stream_file();
    int cut;
    cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, file_q.size())) : file_q.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 299) == 0) file_q[i] = 8'($urandom_range(0, 255));
      send_word(file_q[i], 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: end of an empty file, bad magic, bad type word
    send_word(8'd0, 1'b1);
    send_word(8'd0, 1'b1);
    send_word(8'd255, 1'b0);
    send_word(8'd7, 1'b1);
    file_q = '{8'd42, 8'd114, 8'd109, 8'd118, 8'd0, 8'd2};
    foreach (file_q[i]) send_word(file_q[i], 1'b0);
    send_word(8'd128, 1'b1);
    file_q = '{8'd42, 8'd114, 8'd109, 8'd118, 8'd1, 8'd1};
    foreach (file_q[i]) send_word(file_q[i], 1'b0);
    send_word(8'd0, 1'b1);

    // random files
    while (sent < TARGET_WORDS) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      build_file();
      stream_file();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: replay_file_stream_parser.f
hw/rtl/rfsp_pkg.sv
hw/rtl/rfsp_front.sv
hw/rtl/rfsp_back.sv
hw/rtl/replay_file_stream_parser.sv
tb/record_checker.sv
tb/testbench.sv
